@@ design/abr_pkg.sv @@
`timescale 1ns / 1ps

package abr_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_TICK   = 3'd0;
  localparam cmd_t CMD_ON     = 3'd1;
  localparam cmd_t CMD_OFF    = 3'd2;
  localparam cmd_t CMD_ADJUST = 3'd3;
  localparam cmd_t CMD_SNAP   = 3'd4;

  localparam int DEF_FULL_SCALE    = 1000;
  localparam int DEF_FRACTION_BITS = 8;

  // integer part of the level and width of the Q0.16 gain
  localparam int LEVEL_INT_W = 10;
  localparam int GAIN_W      = 16;
  localparam int DELTA_W     = 16;

  // gain = base + |diff| * slope, slope held in units of 2^-26
  localparam logic [GAIN_W-1:0] GAIN_BASE  = 16'd17039;
  localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd55706;
  localparam logic [GAIN_W-1:0] GAIN_SLOPE = 16'd28186;
  localparam int SLOPE_EXTRA_SHIFT = 10;

  localparam int RESET_LEVEL_NOM = 500;

endpackage

@@ design/abr_mul.sv @@
`timescale 1ns / 1ps

module abr_mul #(
  parameter int A_W = 18,
  parameter int B_W = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] p
);

  // registered product, shared by the gain and step passes
  always_ff @(posedge clk) begin
    if (en) begin
      p <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end
  end

endmodule

@@ design/adaptive_brightness_ramp.sv @@
`timescale 1ns / 1ps

// a tick word runs S_DIFF, S_MUL1, S_GAIN, S_MUL2, S_STEP, S_DUTY, S_DONE, skipping
// from S_MUL1 to S_DUTY when the filter is already within half a unit of the target;
// other words go straight to S_DONE, which waits until the output is free; a new word
// is taken only in S_IDLE; the gain and step products share a single registered multiplier in turn
// reset (synchronous, active high): lamp flag off, target, filter and internal duty at
// the nominal mid level (clamped to full scale), no result pending

module adaptive_brightness_ramp #(
  parameter int FULL_SCALE    = abr_pkg::DEF_FULL_SCALE,
  parameter int FRACTION_BITS = abr_pkg::DEF_FRACTION_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  abr_pkg::cmd_t               command,
  input  logic signed [abr_pkg::DELTA_W-1:0] delta,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        lamp_on,
  output logic [abr_pkg::LEVEL_INT_W-1:0] duty,
  output logic                        duty_write
);
  import abr_pkg::*;

  localparam int LW = LEVEL_INT_W + FRACTION_BITS;
  localparam int PW = LW + GAIN_W;
  localparam int SUM_W = DELTA_W + 2;
  localparam int SLOPE_SHIFT = FRACTION_BITS + SLOPE_EXTRA_SHIFT;
  localparam int RESET_LEVEL = (FULL_SCALE < RESET_LEVEL_NOM) ? FULL_SCALE : RESET_LEVEL_NOM;
  localparam logic [LEVEL_INT_W-1:0] RESET_LVL = LEVEL_INT_W'(RESET_LEVEL);
  localparam logic [LEVEL_INT_W-1:0] FULL_LVL  = LEVEL_INT_W'(FULL_SCALE);
  localparam logic [LW-1:0] HALF       = LW'(1) << (FRACTION_BITS - 1);
  localparam logic [LW-1:0] STEP_FLOOR = LW'(5) << (FRACTION_BITS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIFF = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_GAIN = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_STEP = 3'd5;
  localparam logic [2:0] S_DUTY = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]             state;
  logic                   on_flag;
  logic [LEVEL_INT_W-1:0] target;
  logic [LW-1:0]          filt;
  logic [LEVEL_INT_W-1:0] cur_duty;
  logic                   wr;
  logic [LW-1:0]          mag;
  logic                   up;
  logic [GAIN_W-1:0]      gain;

  logic                   mul_en;
  logic [GAIN_W-1:0]      mul_b;
  logic [PW-1:0]          prod;

  logic [LW-1:0]          tgt;
  logic signed [SUM_W-1:0] adj_sum;
  logic [LEVEL_INT_W-1:0] adj_lvl;
  logic [PW-1:0]          slope_sh;
  logic [GAIN_W:0]        gain_sum;
  logic [GAIN_W-1:0]      gain_next;
  logic [LW-1:0]          step_raw;
  logic [LW-1:0]          step;
  logic [LW:0]            round_sum;
  logic                   out_free;

  abr_mul #(
    .A_W(LW),
    .B_W(GAIN_W)
  ) u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (mag),
    .b  (mul_b),
    .p  (prod)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign tgt      = {target, FRACTION_BITS'(0)};
  assign mul_en   = (state == S_MUL1) || (state == S_MUL2);
  assign mul_b    = (state == S_MUL1) ? GAIN_SLOPE : gain;

  // saturating target update
  always_comb begin
    adj_sum = $signed({{(SUM_W-LEVEL_INT_W){1'b0}}, target}) +
              $signed({{(SUM_W-DELTA_W){delta[DELTA_W-1]}}, delta});
    if (adj_sum < 0) begin
      adj_lvl = '0;
    end else if (adj_sum > $signed(SUM_W'(FULL_SCALE))) begin
      adj_lvl = FULL_LVL;
    end else begin
      adj_lvl = adj_sum[LEVEL_INT_W-1:0];
    end
  end

  always_comb begin
    slope_sh = prod >> SLOPE_SHIFT;
    gain_sum = {1'b0, GAIN_BASE} + slope_sh[GAIN_W:0];
    if (gain_sum > {1'b0, GAIN_MAX}) begin
      gain_next = GAIN_MAX;
    end else begin
      gain_next = gain_sum[GAIN_W-1:0];
    end
  end

  // step is raised to the minimum but never runs past the target
  always_comb begin
    step_raw = prod[PW-1:GAIN_W];
    step     = (step_raw < STEP_FLOOR) ? STEP_FLOOR : step_raw;
    if (step > mag) begin
      step = mag;
    end
  end

  assign round_sum = {1'b0, filt} + {1'b0, HALF};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      on_flag   <= 1'b0;
      target    <= RESET_LVL;
      filt      <= {RESET_LVL, FRACTION_BITS'(0)};
      cur_duty  <= RESET_LVL;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (command == CMD_TICK) ? S_DIFF : S_DONE;
            case (command)
              CMD_TICK: begin
                wr <= on_flag;
              end
              CMD_ON: begin
                on_flag <= 1'b1;
                wr      <= 1'b1;
              end
              CMD_OFF: begin
                on_flag <= 1'b0;
                wr      <= 1'b0;
              end
              CMD_ADJUST: begin
                target <= adj_lvl;
                wr     <= 1'b0;
              end
              CMD_SNAP: begin
                target   <= adj_lvl;
                filt     <= {adj_lvl, FRACTION_BITS'(0)};
                cur_duty <= adj_lvl;
                wr       <= on_flag;
              end
              default: begin
                wr <= 1'b0;
              end
            endcase
          end
        end
        S_DIFF: begin
          up    <= (tgt >= filt);
          mag   <= (tgt >= filt) ? tgt - filt : filt - tgt;
          state <= S_MUL1;
        end
        S_MUL1: begin
          // within half a unit the filter lands on the target
          if (mag > HALF) begin
            state <= S_GAIN;
          end else begin
            filt  <= tgt;
            state <= S_DUTY;
          end
        end
        S_GAIN: begin
          gain  <= gain_next;
          state <= S_MUL2;
        end
        S_MUL2: begin
          state <= S_STEP;
        end
        S_STEP: begin
          filt  <= up ? filt + step : filt - step;
          state <= S_DUTY;
        end
        S_DUTY: begin
          cur_duty <= round_sum[FRACTION_BITS +: LEVEL_INT_W];
          state    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      lamp_on    <= on_flag;
      duty       <= cur_duty;
      duty_write <= wr;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in progress");

  a_filter_in_range: assert property (@(posedge clk) disable iff (rst)
    filt <= {FULL_LVL, FRACTION_BITS'(0)})
    else $error("filtered level beyond full scale");

  a_duty_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> duty <= FULL_LVL)
    else $error("duty beyond full scale");

  a_write_needs_lamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && duty_write |-> lamp_on)
    else $error("duty written while lamp is off");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import abr_pkg::*;

  localparam int FULL_SCALE = DEF_FULL_SCALE;
  localparam int FRAC       = DEF_FRACTION_BITS;
  localparam int RESET_LVL  = (FULL_SCALE < RESET_LEVEL_NOM) ? FULL_SCALE : RESET_LEVEL_NOM;

  // ramp gain in Q0.16, slope in units of 2^-26
  localparam longint unsigned GAIN_FLOOR_Q16 = 17039;
  localparam longint unsigned GAIN_CAP_Q16   = 55706;
  localparam longint unsigned GAIN_SLOPE_Q26 = 28186;
  localparam longint unsigned HALF_LSB       = longint'(1) << (FRAC - 1);
  localparam longint unsigned MIN_STRIDE     = 5 * HALF_LSB;

  localparam int RANDOM_WORDS = 1750;
  localparam int QUIET_LIMIT  = 4000;

  typedef struct {
    logic                   lamp;
    logic [LEVEL_INT_W-1:0] duty;
    logic                   write;
  } duty_word_t;

  class ramp_scoreboard;
    bit              lamp;
    int              target;
    longint unsigned level;
    bit [LEVEL_INT_W-1:0] duty;
    duty_word_t      expected_duty_q[$];
    int              errors;

    function new();
      lamp   = 1'b0;
      target = RESET_LVL;
      level  = longint'(RESET_LVL) << FRAC;
      duty   = LEVEL_INT_W'(RESET_LVL);
      errors = 0;
    endfunction

    function void shift_target(logic signed [DELTA_W-1:0] d);
      int t;
      t = target + int'(d);
      if (t < 0) t = 0;
      if (t > FULL_SCALE) t = FULL_SCALE;
      target = t;
    endfunction

    // work out the ramp state and the result for one accepted word
    function void note_word(cmd_t c, logic signed [DELTA_W-1:0] d);
      duty_word_t      e;
      longint unsigned aim, gap, gain, stride;
      bit              rising;
      e.write = 1'b0;
      case (c)
        CMD_TICK: begin
          aim = longint'(target) << FRAC;
          rising = aim >= level;
          gap = rising ? aim - level : level - aim;
          if (gap > HALF_LSB) begin
            gain = GAIN_FLOOR_Q16 + ((gap * GAIN_SLOPE_Q26) >> (FRAC + SLOPE_EXTRA_SHIFT));
            if (gain > GAIN_CAP_Q16) gain = GAIN_CAP_Q16;
            stride = (gap * gain) >> 16;
            if (stride < MIN_STRIDE) stride = MIN_STRIDE;
            // never overshoot the target
            if (stride > gap) stride = gap;
            level = rising ? level + stride : level - stride;
          end else begin
            level = aim;
          end
          duty = LEVEL_INT_W'((level + HALF_LSB) >> FRAC);
          e.write = lamp;
        end
        CMD_ON: begin
          lamp = 1'b1;
          e.write = 1'b1;
        end
        CMD_OFF: lamp = 1'b0;
        CMD_ADJUST: shift_target(d);
        CMD_SNAP: begin
          shift_target(d);
          level = longint'(target) << FRAC;
          duty = LEVEL_INT_W'(target);
          e.write = lamp;
        end
        default: ;
      endcase
      e.lamp = lamp;
      e.duty = duty;
      expected_duty_q.push_back(e);
    endfunction

    function void check_word(logic l, logic [LEVEL_INT_W-1:0] du, logic w);
      duty_word_t e;
      if (expected_duty_q.size() == 0) begin
        $error("result word with nothing expected: lamp_on=%0d duty=%0d duty_write=%0d",
               l, du, w);
        errors++;
        return;
      end
      e = expected_duty_q.pop_front();
      if (l !== e.lamp) begin
        $error("lamp_on: expected %0d, got %0d", e.lamp, l);
        errors++;
      end
      if (du !== e.duty) begin
        $error("duty: expected %0d, got %0d", e.duty, du);
        errors++;
      end
      if (w !== e.write) begin
        $error("duty_write: expected %0d, got %0d", e.write, w);
        errors++;
      end
    endfunction

    function int pending();
      return expected_duty_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  cmd_t                   command = CMD_TICK;
  logic signed [DELTA_W-1:0] delta = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   lamp_on;
  logic [LEVEL_INT_W-1:0] duty;
  logic                   duty_write;

  int send_idle  = 0;
  int recv_stall = 0;
  int quiet_cycles = 0;

  ramp_scoreboard sb = new();

  adaptive_brightness_ramp #(
    .FULL_SCALE   (FULL_SCALE),
    .FRACTION_BITS(FRAC)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .delta     (delta),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .lamp_on   (lamp_on),
    .duty      (duty),
    .duty_write(duty_write)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side: random back-pressure, check every accepted word
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_word(lamp_on, duty, duty_write);
      out_ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(input cmd_t c, input logic signed [DELTA_W-1:0] d);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= c;
    delta    <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(c, d);
  endtask

  initial begin
    int                     phase, n, r, v;
    cmd_t                   c;
    logic signed [DELTA_W-1:0] d;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    send_idle  = 23;
    recv_stall = 67;

    // directed: saturation both ways, min step, overshoot guard, snap window
    send_word(CMD_TICK, 16'sd0);
    send_word(CMD_ON, 16'sd0);
    send_word(CMD_TICK, 16'sd0);
    send_word(CMD_ADJUST, 16'sh7fff);
    repeat (4) send_word(CMD_TICK, 16'sd0);
    send_word(CMD_ON, 16'sd0);
    send_word(CMD_ADJUST, 16'sh8000);
    send_word(CMD_TICK, 16'sd0);
    send_word(CMD_SNAP, 16'sd0);
    send_word(CMD_ADJUST, 16'sd3);
    send_word(CMD_TICK, 16'sd0);
    send_word(CMD_TICK, 16'sd0);
    send_word(CMD_ADJUST, -16'sd2);
    send_word(CMD_TICK, 16'sd0);
    send_word(CMD_OFF, 16'sd0);
    send_word(CMD_OFF, 16'sd0);
    send_word(CMD_TICK, 16'sd0);
    send_word(CMD_SNAP, 16'sd500);
    send_word(cmd_t'(CMD_SNAP + 1), 16'sh7fff);
    send_word(cmd_t'(CMD_SNAP + 2), 16'sh8000);
    send_word(cmd_t'(CMD_SNAP + 3), -16'sd1);
    send_word(CMD_ON, 16'sd0);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle = 23; recv_stall = 67; end
        1: begin send_idle = 67; recv_stall = 23; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      for (n = 0; n < RANDOM_WORDS / 3; n++) begin
        r = $urandom_range(99);
        if (r < 45)      c = CMD_TICK;
        else if (r < 55) c = CMD_ON;
        else if (r < 62) c = CMD_OFF;
        else if (r < 80) c = CMD_ADJUST;
        else if (r < 94) c = CMD_SNAP;
        else             c = cmd_t'($urandom_range(7, CMD_SNAP + 1));
        r = $urandom_range(99);
        if (r < 60)      v = int'($urandom_range(200)) - 100;
        else if (r < 85) v = int'($urandom_range(2400)) - 1200;
        else             v = int'($urandom_range(16'hffff));
        d = DELTA_W'(v);
        send_word(c, d);
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
